// ===== rtl/core/sha256_pkg.sv =====
// SHA-256 hasher package: round constants, initial hash values, command and
// status structs shared by the controller and the datapath. No dependencies.
package sha256_pkg;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] START_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    // byte source for a buffer write
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_MARK = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic      push;       // write one byte, advance fill count
        byte_src_t src;
        logic      add_len;    // add 8 to the bit count
        logic      snap_len;   // latch bit count for padding
        logic      comp_start; // load working vars from chain
        logic      comp_round; // run one round
        logic      comp_fold;  // add working vars into chain
        logic      reset_msg;  // chain, count, length back to start
        logic      shift_out;  // rotate chain for digest output
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } dp_status_t;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha256_datapath.sv =====
// SHA-256 datapath: block buffer held in the message schedule window, round
// logic, chain words. Depends on sha256_pkg.
module sha256_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::dp_cmd_t    cmd,
    input  logic [7:0]             data_byte,
    output sha256_pkg::dp_status_t status,
    output logic [31:0]            head_word
);

    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [63:0] snap_reg;
    logic [5:0]  round_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] var_reg [8];
    logic [31:0] w_reg [16];
    logic [7:0]  wr_byte;

    always_comb
    begin
        case (cmd.src)
            sha256_pkg::SRC_DATA: wr_byte = data_byte;
            sha256_pkg::SRC_MARK: wr_byte = sha256_pkg::PAD_MARK;
            sha256_pkg::SRC_ZERO: wr_byte = 8'h00;
            sha256_pkg::SRC_LEN:  wr_byte = snap_reg[63:56];
            default:              wr_byte = 8'h00;
        endcase
    end

    logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1;
    always_comb
    begin
        s0    = sha256_pkg::ror32(w_reg[1], 7) ^ sha256_pkg::ror32(w_reg[1], 18)
                ^ (w_reg[1] >> 3);
        s1    = sha256_pkg::ror32(w_reg[14], 17) ^ sha256_pkg::ror32(w_reg[14], 19)
                ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        big1  = sha256_pkg::ror32(var_reg[4], 6) ^ sha256_pkg::ror32(var_reg[4], 11)
                ^ sha256_pkg::ror32(var_reg[4], 25);
        ch    = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        t1    = var_reg[7] + big1 + ch + sha256_pkg::ROUND_K[round_reg] + w_reg[0];
        big0  = sha256_pkg::ror32(var_reg[0], 2) ^ sha256_pkg::ror32(var_reg[0], 13)
                ^ sha256_pkg::ror32(var_reg[0], 22);
        maj   = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                ^ (var_reg[1] & var_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            len_reg     <= '0;
            round_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha256_pkg::START_WORDS[i];
            end
        end
        else
        begin
            if (cmd.push)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.add_len)
            begin
                len_reg <= len_reg + 64'd8;
            end
            if (cmd.comp_start)
            begin
                round_reg <= '0;
            end
            else if (cmd.comp_round)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.comp_fold)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
            else if (cmd.reset_msg)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= sha256_pkg::START_WORDS[i];
                end
                fill_reg <= '0;
                len_reg  <= '0;
            end
            else if (cmd.shift_out)
            begin
                for (int i = 0; i < 7; i++)
                begin
                    chain_reg[i] <= chain_reg[i + 1];
                end
                chain_reg[7] <= chain_reg[0];
            end
        end
    end

    // payload: snapshot, working vars, schedule window; bytes land straight
    // in the window, big-endian within each word
    always_ff @(posedge clk)
    begin
        if (cmd.snap_len)
        begin
            snap_reg <= len_reg;
        end
        else if (cmd.push && cmd.src == sha256_pkg::SRC_LEN)
        begin
            snap_reg <= {snap_reg[55:0], 8'h00};
        end
        if (cmd.comp_start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                var_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.comp_round)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + big0 + maj;
        end
        if (cmd.comp_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
        else if (cmd.push)
        begin
            case (fill_reg[1:0])
                2'd0:    w_reg[fill_reg[5:2]][31:24] <= wr_byte;
                2'd1:    w_reg[fill_reg[5:2]][23:16] <= wr_byte;
                2'd2:    w_reg[fill_reg[5:2]][15:8]  <= wr_byte;
                default: w_reg[fill_reg[5:2]][7:0]   <= wr_byte;
            endcase
        end
    end

    assign status.fill       = fill_reg;
    assign status.round_last = (round_reg == 6'd63);
    assign head_word         = chain_reg[0];

endmodule

// ===== rtl/core/sha256_ctrl.sv =====
// SHA-256 controller: sequences absorb, padding, compression and digest
// output. Depends on sha256_pkg.
module sha256_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_action,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_index,
    input  sha256_pkg::dp_status_t status,
    output sha256_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;     // in finish sequence
    logic [3:0] padlen_reg, padlen_next; // length bytes written
    logic [2:0] idx_reg, idx_next;
    logic       acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign acc       = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_index = idx_reg;

    always_comb
    begin
        state_next  = state_reg;
        fin_next    = fin_reg;
        padlen_next = padlen_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        cmd.src     = sha256_pkg::SRC_DATA;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    cmd.push = 1'b1;
                    if (!in_action)
                    begin
                        cmd.add_len = 1'b1;
                    end
                    else
                    begin
                        cmd.src      = sha256_pkg::SRC_MARK;
                        cmd.snap_len = 1'b1;
                        fin_next     = 1'b1;
                        padlen_next  = '0;
                    end
                    if (status.fill == 6'd63)
                    begin
                        state_next = ST_START;
                    end
                    else if (in_action)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // zeros up to byte 56 of a block, then the length bytes; a
                // mark at or past byte 56 leaves the rest of that block zero
                cmd.push = 1'b1;
                if ((status.fill == sha256_pkg::LEN_OFFSET || padlen_reg != 4'd0)
                    && padlen_reg != 4'd8)
                begin
                    cmd.src     = sha256_pkg::SRC_LEN;
                    padlen_next = padlen_reg + 4'd1;
                end
                else
                begin
                    cmd.src = sha256_pkg::SRC_ZERO;
                end
                if (status.fill == 6'd63)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.comp_start = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.comp_round = 1'b1;
                if (status.round_last)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.comp_fold = 1'b1;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (padlen_reg == 4'd8)
                begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.reset_msg = 1'b1;
                        fin_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.shift_out = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fin_reg    <= 1'b0;
            padlen_reg <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            padlen_reg <= padlen_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

// ===== rtl/core/sha256_byte_stream_hasher_top.sv =====
// SHA-256 byte stream hasher, top level: controller plus datapath.
// Depends on sha256_pkg, sha256_ctrl, sha256_datapath.
//
// Feed the message one byte per input word with tuser low; send a word with
// tuser high to finish. The 64th byte of a block starts the compression: a
// load, one SHA-256 round per cycle in the shared round unit, and a fold,
// with s_tready low meanwhile; other bytes leave it high. Finish writes the
// padding one byte per cycle through the block buffer's single write port,
// runs one or two compressions, then presents eight digest words, most
// significant first, with the index in tuser and tlast on the eighth. The
// input is held off (s_tready low) from finish until the last digest word is
// taken; then the hasher is back at its initial state for the next message.
module sha256_byte_stream_hasher_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] data_byte
    input  logic        s_tuser,  // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] digest_word
    output logic [2:0]  m_tuser,  // [2:0] word_index
    output logic        m_tlast
);

    sha256_pkg::dp_cmd_t    cmd;
    sha256_pkg::dp_status_t status;

    sha256_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (m_tuser),
        .status    (status),
        .cmd       (cmd)
    );

    sha256_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (s_tdata),
        .status    (status),
        .head_word (m_tdata)
    );

    assign m_tlast = (m_tuser == 3'd7);

endmodule

// ===== rtl/core/sha256_checker.sv =====
// SHA-256 hasher port checker and its bind to the top level.
// Depends only on the top level's ports.
module sha256_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while digest out");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
        else $error("tlast mismatch");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
        else $error("digest index skip");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled word changed");

    a_finish_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready)
        else $error("input taken during finish");

endmodule

bind sha256_byte_stream_hasher_top sha256_checker u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
